// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the ring detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clk edge while out of reset.
`define RDAA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clk edge while out of reset.
`define RDAA_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define RDAA_ASSERT(lbl, prop, msg)
`define RDAA_NEVER(lbl, cond, msg)

`endif

`endif

// ===== hw/rtl/rdaa_pkg.sv =====
// Types and constants of the ring detector and hook controller.
package rdaa_pkg;

	localparam int unsigned QUIET_W      = 11;
	localparam int unsigned WEDGE_W      = 16;
	localparam int unsigned FREQ_W       = 16;
	localparam int unsigned DELAY_W      = 20;
	localparam int unsigned CFG_DATA_W   = 20;
	localparam int unsigned CFG_IDX_W    = 3;
	localparam int unsigned EDGE_OUT_W   = 32;
	// window_edges * 50000 fits in 32 bits
	localparam int unsigned FREQ_DVD_W   = 32;

	localparam logic [QUIET_W-1:0] QUIET_MAX   = 11'd2047;
	localparam logic [WEDGE_W-1:0] WEDGE_MAX   = 16'hFFFF;
	localparam logic [FREQ_W-1:0]  FREQ_MAX    = 16'hFFFF;
	localparam logic [WEDGE_W-1:0] FREQ_SCALE  = 16'd50000;

	localparam logic [QUIET_W-1:0] TIMEOUT_RST = 11'd1200;
	localparam logic [QUIET_W-1:0] WINDOW_RST  = 11'd250;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLOCK_ENABLED   = 3'd0,
		CFG_AUTO_ANSWER_ON  = 3'd1,
		CFG_ANSWER_DELAY    = 3'd2,
		CFG_IDLE_TIMEOUT    = 3'd3,
		CFG_FREQ_MIN_WINDOW = 3'd4,
		CFG_SOURCE_MCU      = 3'd5,
		CFG_OH_ACTIVE_HIGH  = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CMD_NONE     = 2'd0,
		CMD_OFF_HOOK = 2'd1,
		CMD_ON_HOOK  = 2'd2
	} hook_cmd_t;

	typedef enum logic [3:0] {
		ST_DISABLED = 4'd0,
		ST_RUNNING  = 4'd1,
		ST_IDLE     = 4'd2,
		ST_OFFHOOK  = 4'd3,
		ST_RINGING  = 4'd4,
		ST_ANSWERED = 4'd5,
		ST_ARMED    = 4'd6,
		ST_OFFREQ   = 4'd7,
		ST_ONREQ    = 4'd8,
		ST_REFUSED  = 4'd9
	} status_t;

	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// ===== hw/rtl/rdaa_if.sv =====
// Item channels of the ring detector: sample input and status output.
interface rdaa_in_if;
	logic       valid;
	logic       ready;
	logic       ri_sample;
	logic       tick;
	logic [1:0] cmd;

	modport source (output valid, output ri_sample, output tick, output cmd, input ready);
	modport sink   (input valid, input ri_sample, input tick, input cmd, output ready);
endinterface

interface rdaa_out_if;
	logic        valid;
	logic        ready;
	logic        hook_drive;
	logic        off_hook;
	logic        ringing_now;
	logic        ri_high;
	logic [15:0] ring_freq_centihz;
	logic [31:0] edge_total;
	logic [3:0]  status_code;

	modport source (
		output valid, output hook_drive, output off_hook, output ringing_now,
		output ri_high, output ring_freq_centihz, output edge_total,
		output status_code, input ready
	);
	modport sink (
		input valid, input hook_drive, input off_hook, input ringing_now,
		input ri_high, input ring_freq_centihz, input edge_total,
		input status_code, output ready
	);
endinterface

// ===== hw/rtl/ring_detect_auto_answer_unit.sv =====
// Top level of the telephone line ring detector and hook controller.
`include "assert_macros.svh"

// Ring detector and hook controller. Each input item carries one RI sample, a
// one-millisecond tick flag and a hook command (0 none, 1 off-hook, 2 on-hook);
// each accepted item yields exactly one result item with the hook drive, the
// held hook, ringing and RI state, the ring frequency in centihertz, the edge
// total and a status code. Configuration is written through cfg_we/cfg_index/
// cfg_data; the user must write it only while no item is in flight; the block
// does not enforce this. An item with no frequency update passes S_FIN only;
// one that updates the frequency in a ring burst first passes S_LOAD and S_DIV,
// where the 32-step restoring divider forms window_edges*50000/ring_elapsed_ms
// one quotient bit per cycle. The block takes one item at a time; the result
// sits in an output register, so the next item is accepted while it waits.
module ring_detect_auto_answer_unit #(
	parameter int unsigned RING_TIMER_WIDTH = 20,
	parameter int unsigned EDGE_COUNT_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [rdaa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rdaa_pkg::CFG_DATA_W-1:0]    cfg_data,
	rdaa_in_if.sink                            in_ch,
	rdaa_out_if.source                         out_ch
);

	localparam int unsigned RTW = RING_TIMER_WIDTH;
	localparam int unsigned ECW = EDGE_COUNT_WIDTH;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOAD = 4'b0010,
		S_DIV  = 4'b0100,
		S_FIN  = 4'b1000
	} seq_state_t;

	// Configuration registers
	logic                            enabled_q;
	logic                            auto_ans_q;
	logic [rdaa_pkg::DELAY_W-1:0]    delay_q;
	logic [rdaa_pkg::QUIET_W-1:0]    timeout_q;
	logic [rdaa_pkg::QUIET_W-1:0]    window_q;
	logic                            src_mcu_q;
	logic                            oh_high_q;

	// Line state
	logic                            ri_level_q;
	logic                            ringing_q;
	logic                            offhook_q;
	logic [rdaa_pkg::QUIET_W-1:0]    quiet_q;
	logic [RTW-1:0]                  elapsed_q;
	logic [rdaa_pkg::WEDGE_W-1:0]    wedges_q;
	logic [ECW-1:0]                  edge_cnt_q;
	logic [rdaa_pkg::FREQ_W-1:0]     freq_q;
	rdaa_pkg::status_t               status_q;

	// Next line state for the item on the input channel
	logic                            level;
	logic                            ri_level_d;
	logic                            ringing_d;
	logic                            offhook_d;
	logic [rdaa_pkg::QUIET_W-1:0]    quiet_d;
	logic [RTW-1:0]                  elapsed_d;
	logic [rdaa_pkg::WEDGE_W-1:0]    wedges_d;
	logic [ECW-1:0]                  edge_cnt_d;
	logic [rdaa_pkg::FREQ_W-1:0]     freq_d;
	rdaa_pkg::status_t               status_d;
	logic                            burst_end;
	logic                            need_div;

	// Sequencer and output register
	seq_state_t                      state_q;
	logic                            out_valid_q;
	logic                            in_accept;
	logic                            out_load;

	// Divider
	rdaa_pkg::div_ctl_t              div_ctl;
	rdaa_pkg::div_sts_t              div_sts;
	logic [rdaa_pkg::FREQ_DVD_W-1:0] div_dividend;
	logic [rdaa_pkg::FREQ_DVD_W-1:0] div_quot;
	logic [rdaa_pkg::FREQ_W-1:0]     freq_sat;

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q  <= 1'b0;
			auto_ans_q <= 1'b0;
			delay_q    <= '0;
			timeout_q  <= rdaa_pkg::TIMEOUT_RST;
			window_q   <= rdaa_pkg::WINDOW_RST;
			src_mcu_q  <= 1'b0;
			oh_high_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rdaa_pkg::CFG_BLOCK_ENABLED:   enabled_q  <= cfg_data[0];
				rdaa_pkg::CFG_AUTO_ANSWER_ON:  auto_ans_q <= cfg_data[0];
				rdaa_pkg::CFG_ANSWER_DELAY:    delay_q    <= cfg_data[rdaa_pkg::DELAY_W-1:0];
				rdaa_pkg::CFG_IDLE_TIMEOUT:    timeout_q  <= cfg_data[rdaa_pkg::QUIET_W-1:0];
				rdaa_pkg::CFG_FREQ_MIN_WINDOW: window_q   <= cfg_data[rdaa_pkg::QUIET_W-1:0];
				rdaa_pkg::CFG_SOURCE_MCU:      src_mcu_q  <= cfg_data[0];
				rdaa_pkg::CFG_OH_ACTIVE_HIGH:  oh_high_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Per-item update: tick first, then the RI edge, then burst end, frequency
	// and auto-answer, and the hook command last.
	always_comb begin
		level      = in_ch.ri_sample ^ src_mcu_q;
		ri_level_d = ri_level_q;
		ringing_d  = ringing_q;
		offhook_d  = offhook_q;
		quiet_d    = quiet_q;
		elapsed_d  = elapsed_q;
		wedges_d   = wedges_q;
		edge_cnt_d = edge_cnt_q;
		freq_d     = freq_q;
		status_d   = status_q;
		need_div   = 1'b0;

		if (in_ch.tick) begin
			if (quiet_d != rdaa_pkg::QUIET_MAX) quiet_d = quiet_d + 1'b1;
			if (ringing_d && (elapsed_d != '1)) elapsed_d = elapsed_d + 1'b1;
		end

		if (level != ri_level_d) begin
			ri_level_d = level;
			edge_cnt_d = edge_cnt_d + 1'b1;
			if (wedges_d != rdaa_pkg::WEDGE_MAX) wedges_d = wedges_d + 1'b1;
			quiet_d = '0;
			// in MCU mode only a falling level opens a burst
			if (!ringing_d && (!src_mcu_q || !level)) begin
				ringing_d = 1'b1;
				elapsed_d = '0;
				wedges_d  = rdaa_pkg::WEDGE_W'(1);
			end
		end

		burst_end = ringing_d && (quiet_d > timeout_q) && ri_level_d;

		if (burst_end) begin
			ringing_d = 1'b0;
			freq_d    = '0;
			wedges_d  = '0;
			status_d  = offhook_d ? rdaa_pkg::ST_OFFHOOK : rdaa_pkg::ST_IDLE;
		end else if (ringing_d) begin
			need_div = elapsed_d > RTW'(window_q);
			status_d = rdaa_pkg::ST_RINGING;
			if (!src_mcu_q && auto_ans_q && !offhook_d && (elapsed_d >= RTW'(delay_q))) begin
				if (ri_level_d) begin
					offhook_d = 1'b1;
					status_d  = rdaa_pkg::ST_ANSWERED;
				end else begin
					status_d  = rdaa_pkg::ST_ARMED;
				end
			end
		end else if (src_mcu_q && (status_d == rdaa_pkg::ST_RUNNING)) begin
			status_d = offhook_d ? rdaa_pkg::ST_OFFHOOK : rdaa_pkg::ST_IDLE;
		end

		unique case (in_ch.cmd)
			rdaa_pkg::CMD_OFF_HOOK: begin
				// refuse while RI is low inside a burst
				if (ringing_d && !ri_level_d) begin
					status_d = rdaa_pkg::ST_REFUSED;
				end else begin
					offhook_d = 1'b1;
					status_d  = rdaa_pkg::ST_OFFREQ;
				end
			end
			rdaa_pkg::CMD_ON_HOOK: begin
				offhook_d = 1'b0;
				status_d  = rdaa_pkg::ST_ONREQ;
			end
			default: ;
		endcase
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_accept   = in_ch.valid && in_ch.ready;
	assign out_load    = (state_q == S_FIN) && (!out_valid_q || out_ch.ready);

	// Launch the divider in the cycle after acceptance, from the updated window
	assign div_ctl.start = (state_q == S_LOAD);
	assign div_dividend  = rdaa_pkg::FREQ_DVD_W'(wedges_q) *
	                       rdaa_pkg::FREQ_DVD_W'(rdaa_pkg::FREQ_SCALE);

	rdaa_div #(
		.DVD_W (rdaa_pkg::FREQ_DVD_W),
		.DVS_W (RTW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (div_dividend),
		.divisor  (elapsed_q),
		.sts      (div_sts),
		.quotient (div_quot)
	);

	// Clamp the quotient to 16 bits
	assign freq_sat = (|div_quot[rdaa_pkg::FREQ_DVD_W-1:rdaa_pkg::FREQ_W]) ?
	                  rdaa_pkg::FREQ_MAX : div_quot[rdaa_pkg::FREQ_W-1:0];

	// Sequencer and line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			ri_level_q  <= 1'b1;
			ringing_q   <= 1'b0;
			offhook_q   <= 1'b0;
			quiet_q     <= '0;
			elapsed_q   <= '0;
			wedges_q    <= '0;
			edge_cnt_q  <= '0;
			freq_q      <= '0;
			status_q    <= rdaa_pkg::ST_RUNNING;
		end else begin
			// hold the result until taken; a new one may replace it on the same edge
			out_valid_q <= out_load || (out_valid_q && !out_ch.ready);
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						state_q <= (enabled_q && need_div) ? S_LOAD : S_FIN;
						// disabled: hold every line register
						if (enabled_q) begin
							ri_level_q <= ri_level_d;
							ringing_q  <= ringing_d;
							offhook_q  <= offhook_d;
							quiet_q    <= quiet_d;
							elapsed_q  <= elapsed_d;
							wedges_q   <= wedges_d;
							edge_cnt_q <= edge_cnt_d;
							freq_q     <= freq_d;
							status_q   <= status_d;
						end
					end
				end
				S_LOAD: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_sts.done) begin
						freq_q  <= freq_sat;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ch.hook_drive        <= enabled_q && (oh_high_q ? offhook_q : !offhook_q);
			out_ch.off_hook          <= offhook_q;
			out_ch.ringing_now       <= ringing_q;
			out_ch.ri_high           <= ri_level_q;
			out_ch.ring_freq_centihz <= freq_q;
			out_ch.edge_total        <= rdaa_pkg::EDGE_OUT_W'(edge_cnt_q);
			out_ch.status_code       <= enabled_q ? status_q : rdaa_pkg::ST_DISABLED;
		end
	end

	assign out_ch.valid = out_valid_q;

	`RDAA_ASSERT(a_one_item, in_accept |=> !in_ch.ready, "second item taken while busy")
	`RDAA_ASSERT(a_done_in_div, div_sts.done |-> (state_q == S_DIV), "divider result outside S_DIV")
	`RDAA_NEVER(a_start_busy, div_ctl.start && div_sts.busy, "divider restarted while busy")
	`RDAA_ASSERT(a_freq_idle, !ringing_q |-> (freq_q == '0), "frequency held outside a burst")

endmodule

// ===== hw/rtl/rdaa_div.sv =====
// Restoring divider, one quotient bit per cycle, for the ring frequency estimate.
module rdaa_div #(
	parameter int unsigned DVD_W = 32,
	parameter int unsigned DVS_W = 20
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rdaa_pkg::div_ctl_t   ctl,
	input  logic [DVD_W-1:0]     dividend,
	input  logic [DVS_W-1:0]     divisor,
	output rdaa_pkg::div_sts_t   sts,
	output logic [DVD_W-1:0]     quotient
);

	localparam int unsigned CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

	logic [DVD_W-1:0] dq_q;     // dividend shifting out, quotient shifting in
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0]   rem_sh;
	logic             fits;
	logic [DVS_W:0]   rem_sub;

	assign rem_sh  = {rem_q, dq_q[DVD_W-1]};
	assign fits    = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
			dq_q  <= {dq_q[DVD_W-2:0], fits};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = dq_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the ring detector and hook controller.
`timescale 1ns / 100ps

module tb_top;

	// Unused hook command code: the block must ignore it.
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// One result item as the block reports it.
	typedef struct packed {
		logic                        hook_drive;
		logic                        off_hook;
		logic                        ringing_now;
		logic                        ri_high;
		logic [rdaa_pkg::FREQ_W-1:0] freq;
		logic [31:0]                 edge_total;
		rdaa_pkg::status_t           status;
	} line_result_t;

	// One full set of configuration registers.
	typedef struct {
		logic                         en;
		logic                         auto_on;
		logic [rdaa_pkg::DELAY_W-1:0] answer_delay;
		logic [rdaa_pkg::QUIET_W-1:0] timeout;
		logic [rdaa_pkg::QUIET_W-1:0] window;
		logic                         mcu;
		logic                         pol;
	} line_setting_t;

	// Line state tracker and store of expected line reports.
	class line_scoreboard;
		logic                         en, auto_on, mcu, pol;
		logic [rdaa_pkg::DELAY_W-1:0] answer_delay;
		logic [rdaa_pkg::QUIET_W-1:0] timeout, window;
		logic                         ri_lvl, ringing, offhook;
		logic [rdaa_pkg::QUIET_W-1:0] quiet;
		logic [19:0]                  elapsed;
		logic [rdaa_pkg::WEDGE_W-1:0] wedges;
		logic [31:0]                  edges;
		logic [rdaa_pkg::FREQ_W-1:0]  freq;
		rdaa_pkg::status_t            status;
		line_result_t                 expected_reports[$];
		int                           errors;
		int                           checked;

		function new();
			en = 1'b0; auto_on = 1'b0; answer_delay = '0;
			timeout = rdaa_pkg::TIMEOUT_RST; window = rdaa_pkg::WINDOW_RST;
			mcu = 1'b0; pol = 1'b1;
			ri_lvl = 1'b1; ringing = 1'b0; offhook = 1'b0; quiet = '0;
			elapsed = '0; wedges = '0; edges = '0; freq = '0;
			status = rdaa_pkg::ST_RUNNING;
			errors = 0; checked = 0;
		endfunction

		function void set_reg(rdaa_pkg::cfg_reg_t idx, logic [rdaa_pkg::CFG_DATA_W-1:0] val);
			unique case (idx)
				rdaa_pkg::CFG_BLOCK_ENABLED:   en = val[0];
				rdaa_pkg::CFG_AUTO_ANSWER_ON:  auto_on = val[0];
				rdaa_pkg::CFG_ANSWER_DELAY:    answer_delay = val[rdaa_pkg::DELAY_W-1:0];
				rdaa_pkg::CFG_IDLE_TIMEOUT:    timeout = val[rdaa_pkg::QUIET_W-1:0];
				rdaa_pkg::CFG_FREQ_MIN_WINDOW: window = val[rdaa_pkg::QUIET_W-1:0];
				rdaa_pkg::CFG_SOURCE_MCU:      mcu = val[0];
				rdaa_pkg::CFG_OH_ACTIVE_HIGH:  pol = val[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction

		// Advance the line state by one accepted item and queue its report.
		function void note_input(logic ri, logic tk, logic [1:0] c);
			logic            level;
			logic [63:0]     quo;
			line_result_t    r;
			level = ri ^ mcu;
			if (en) begin
				if (tk) begin
					if (quiet < rdaa_pkg::QUIET_MAX) quiet++;
					if (ringing && elapsed != '1) elapsed++;
				end
				if (level != ri_lvl) begin
					ri_lvl = level;
					edges++;
					if (wedges < rdaa_pkg::WEDGE_MAX) wedges++;
					quiet = '0;
					if (!ringing && (!mcu || !level)) begin
						ringing = 1'b1;
						elapsed = '0;
						wedges = 16'd1;
					end
				end
				if (ringing && quiet > timeout && ri_lvl) begin
					ringing = 1'b0;
					freq = '0;
					wedges = '0;
					status = offhook ? rdaa_pkg::ST_OFFHOOK : rdaa_pkg::ST_IDLE;
				end else if (ringing) begin
					if (elapsed > window) begin
						quo = (64'(wedges) * 64'(rdaa_pkg::FREQ_SCALE)) / 64'(elapsed);
						freq = (quo > 64'(rdaa_pkg::FREQ_MAX)) ?
							rdaa_pkg::FREQ_MAX : quo[rdaa_pkg::FREQ_W-1:0];
					end
					status = rdaa_pkg::ST_RINGING;
					if (!mcu && auto_on && !offhook && elapsed >= answer_delay) begin
						if (ri_lvl) begin
							offhook = 1'b1;
							status = rdaa_pkg::ST_ANSWERED;
						end else begin
							status = rdaa_pkg::ST_ARMED;
						end
					end
				end else if (mcu && status == rdaa_pkg::ST_RUNNING) begin
					status = offhook ? rdaa_pkg::ST_OFFHOOK : rdaa_pkg::ST_IDLE;
				end
				unique case (c)
					rdaa_pkg::CMD_OFF_HOOK: begin
						if (ringing && !ri_lvl) begin
							status = rdaa_pkg::ST_REFUSED;
						end else begin
							offhook = 1'b1;
							status = rdaa_pkg::ST_OFFREQ;
						end
					end
					rdaa_pkg::CMD_ON_HOOK: begin
						offhook = 1'b0;
						status = rdaa_pkg::ST_ONREQ;
					end
					default: ;
				endcase
			end
			r.hook_drive  = en ? (pol ? offhook : ~offhook) : 1'b0;
			r.off_hook    = offhook;
			r.ringing_now = ringing;
			r.ri_high     = ri_lvl;
			r.freq        = freq;
			r.edge_total  = edges;
			r.status      = en ? status : rdaa_pkg::ST_DISABLED;
			expected_reports.push_back(r);
		endfunction

		function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s: expected %0d, got %0d", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(line_result_t act);
			line_result_t ex;
			if (expected_reports.size() == 0) begin
				$error("result item arrived with no item outstanding");
				errors++;
				return;
			end
			ex = expected_reports.pop_front();
			checked++;
			cmp_field("hook_drive", 32'(ex.hook_drive), 32'(act.hook_drive));
			cmp_field("off_hook", 32'(ex.off_hook), 32'(act.off_hook));
			cmp_field("ringing_now", 32'(ex.ringing_now), 32'(act.ringing_now));
			cmp_field("ri_high", 32'(ex.ri_high), 32'(act.ri_high));
			cmp_field("ring_freq_centihz", 32'(ex.freq), 32'(act.freq));
			cmp_field("edge_total", ex.edge_total, act.edge_total);
			cmp_field("status_code", 32'(ex.status), 32'(act.status));
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [rdaa_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [rdaa_pkg::CFG_DATA_W-1:0] cfg_data;

	rdaa_in_if  in_ch();
	rdaa_out_if out_ch();

	ring_detect_auto_answer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	line_scoreboard sb = new();
	line_setting_t  cur;
	int             tx_idle_pct = 0;
	int             rx_idle_pct = 0;
	int             rx_hold_len = 0;
	int             items_sent  = 0;
	int             settings_run = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run, every item taking the full
	// divider time and the longest receiver stall.
	initial begin
		#8000000;
		$display("end of test: mismatches");
		$finish;
	end

	// Receiver: drop ready at random, or hold it low for a counted stretch
	// when asked, so that the output register fills and the input stalls.
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold_len != 0) begin
				out_ch.ready <= 1'b0;
				repeat (rx_hold_len) @(negedge clk);
				rx_hold_len = 0;
			end
			out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Sample both channels at the rising edge; note the item before checking
	// so that ordering within the edge never matters.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				sb.note_input(in_ch.ri_sample, in_ch.tick, in_ch.cmd);
			if (out_ch.valid && out_ch.ready)
				sb.check_result('{out_ch.hook_drive, out_ch.off_hook, out_ch.ringing_now,
					out_ch.ri_high, out_ch.ring_freq_centihz, out_ch.edge_total,
					rdaa_pkg::status_t'(out_ch.status_code)});
		end
	end

	// Offer one item, after a random gap, and hold it until accepted.
	task automatic send_item(logic ri, logic tk, logic [1:0] c);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(0, 99) < tx_idle_pct) gap++;
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.ri_sample <= ri;
		in_ch.tick      <= tk;
		in_ch.cmd       <= c;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
	endtask

	// Stop offering and wait for every outstanding result, then let the
	// block settle before anything is reconfigured.
	task automatic drain_results();
		int n;
		@(negedge clk);
		in_ch.valid <= 1'b0;
		n = 0;
		while (sb.pending() != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(rdaa_pkg::cfg_reg_t idx, logic [rdaa_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	task automatic apply_setting(line_setting_t s);
		write_reg(rdaa_pkg::CFG_BLOCK_ENABLED, rdaa_pkg::CFG_DATA_W'(s.en));
		write_reg(rdaa_pkg::CFG_AUTO_ANSWER_ON, rdaa_pkg::CFG_DATA_W'(s.auto_on));
		write_reg(rdaa_pkg::CFG_ANSWER_DELAY, rdaa_pkg::CFG_DATA_W'(s.answer_delay));
		write_reg(rdaa_pkg::CFG_IDLE_TIMEOUT, rdaa_pkg::CFG_DATA_W'(s.timeout));
		write_reg(rdaa_pkg::CFG_FREQ_MIN_WINDOW, rdaa_pkg::CFG_DATA_W'(s.window));
		write_reg(rdaa_pkg::CFG_SOURCE_MCU, rdaa_pkg::CFG_DATA_W'(s.mcu));
		write_reg(rdaa_pkg::CFG_OH_ACTIVE_HIGH, rdaa_pkg::CFG_DATA_W'(s.pol));
		cur = s;
		settings_run++;
	endtask

	// Mostly no command, now and then a hook request or the unused code.
	function automatic logic [1:0] pick_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 88) return rdaa_pkg::CMD_NONE;
		if (r < 94) return rdaa_pkg::CMD_OFF_HOOK;
		if (r < 98) return rdaa_pkg::CMD_ON_HOOK;
		return CMD_UNUSED;
	endfunction

	// Line settings per phase: fixed corners first, then random small values.
	function automatic line_setting_t setting_for(int ph);
		line_setting_t s;
		case (ph)
			0: s = '{1'b1, 1'b1, 20'd0,      11'd10,   11'd4,    1'b0, 1'b1};
			1: s = '{1'b1, 1'b1, 20'd20,     11'd1,    11'd1,    1'b0, 1'b0};
			2: s = '{1'b0, 1'b1, 20'd5,      11'd8,    11'd3,    1'b0, 1'b1};
			3: s = '{1'b1, 1'b0, 20'd0,      11'd12,   11'd0,    1'b1, 1'b1};
			4: s = '{1'b1, 1'b1, 20'd600000, 11'd0,    11'd2047, 1'b0, 1'b1};
			5: s = '{1'b1, 1'b1, 20'd3,      11'd2047, 11'd8,    1'b1, 1'b0};
			default: begin
				s.en           = 1'b1;
				s.auto_on      = ($urandom_range(0, 3) != 0);
				s.answer_delay = 20'($urandom_range(0, 40));
				s.timeout      = 11'($urandom_range(1, 30));
				s.window       = 11'($urandom_range(1, 20));
				s.mcu          = 1'($urandom_range(0, 1));
				s.pol          = 1'($urandom_range(0, 1));
			end
		endcase
		return s;
	endfunction

	// A ring burst with random cadence and content, followed by a quiet
	// stretch at idle level long enough, mostly, to end the burst.
	task automatic ring_episode();
		int   half, pulses, quiet_len;
		logic lvl;
		half      = $urandom_range(1, 6);
		pulses    = $urandom_range(2, 12);
		quiet_len = ((cur.timeout > 40) ? 40 : int'(cur.timeout)) + $urandom_range(0, 4);
		for (int i = 0; i < pulses; i++) begin
			lvl = i[0];
			for (int j = 0; j < half; j++)
				send_item(lvl ^ cur.mcu, ($urandom_range(0, 7) != 0), pick_cmd());
		end
		for (int i = 0; i < quiet_len; i++)
			send_item(1'b1 ^ cur.mcu, 1'b1, pick_cmd());
	endtask

	initial begin
		int  budget, start;
		bit  paused;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		in_ch.valid     = 1'b0;
		in_ch.ri_sample = 1'b0;
		in_ch.tick      = 1'b0;
		in_ch.cmd       = rdaa_pkg::CMD_NONE;
		cur             = '{1'b0, 1'b0, 20'd0, rdaa_pkg::TIMEOUT_RST, rdaa_pkg::WINDOW_RST,
			1'b0, 1'b1};
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: the block is still disabled after reset, so inputs
		// must be ignored and status reads disabled.
		tx_idle_pct = 6;
		rx_idle_pct = 73;
		send_item(1'b0, 1'b1, rdaa_pkg::CMD_OFF_HOOK);
		send_item(1'b1, 1'b1, CMD_UNUSED);
		drain_results();

		// MCU source: an idle item moves running to idle, an active flag
		// starts a burst, an off-hook request while RI is low is refused,
		// fast edges saturate the frequency, and the quiet timeout ends it.
		apply_setting('{1'b1, 1'b1, 20'd0, 11'd3, 11'd1, 1'b1, 1'b1});
		send_item(1'b0, 1'b1, rdaa_pkg::CMD_NONE);
		send_item(1'b1, 1'b1, rdaa_pkg::CMD_NONE);
		send_item(1'b1, 1'b1, rdaa_pkg::CMD_OFF_HOOK);
		send_item(1'b0, 1'b1, rdaa_pkg::CMD_NONE);
		send_item(1'b1, 1'b0, rdaa_pkg::CMD_NONE);
		send_item(1'b0, 1'b1, CMD_UNUSED);
		repeat (4) send_item(1'b0, 1'b1, rdaa_pkg::CMD_NONE);
		send_item(1'b0, 1'b1, rdaa_pkg::CMD_OFF_HOOK);
		send_item(1'b0, 1'b0, rdaa_pkg::CMD_ON_HOOK);
		drain_results();

		// Direct source, inverted drive, no delay: armed while RI is low,
		// answered once it returns high, then explicit hook requests.
		apply_setting('{1'b1, 1'b1, 20'd0, 11'd3, 11'd1, 1'b0, 1'b0});
		send_item(1'b0, 1'b1, rdaa_pkg::CMD_NONE);
		send_item(1'b1, 1'b1, rdaa_pkg::CMD_NONE);
		send_item(1'b1, 1'b1, rdaa_pkg::CMD_OFF_HOOK);
		send_item(1'b0, 1'b1, rdaa_pkg::CMD_ON_HOOK);
		repeat (5) send_item(1'b1, 1'b1, rdaa_pkg::CMD_NONE);

		// Random phases: sender idles lightly and receiver heavily, then the
		// other way round, then neither.
		for (int ph = 0; ph < 8; ph++) begin
			tx_idle_pct = (ph < 3) ? 6 : (ph < 6) ? 73 : 0;
			rx_idle_pct = (ph < 3) ? 73 : (ph < 6) ? 6 : 0;
			drain_results();
			apply_setting(setting_for(ph));
			// Hold the receiver off while items keep coming, to back the
			// block up into its input.
			if (ph == 6)
				rx_hold_len = 300;
			budget = cur.en ? 115 : 30;
			start  = items_sent;
			paused = 1'b0;
			while (items_sent - start < budget) begin
				// Pause the sender once until every result is in.
				if (ph == 7 && !paused && items_sent - start >= budget / 2) begin
					drain_results();
					paused = 1'b1;
				end
				if ($urandom_range(0, 9) < 7) begin
					ring_episode();
				end else begin
					repeat ($urandom_range(1, 6))
						send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
							2'($urandom_range(0, 3)));
				end
			end
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d expected result items never arrived", sb.pending());
			sb.errors++;
		end
		$display("run covered %0d items over %0d line settings, %0d results compared",
			items_sent, settings_run, sb.checked);
		$display("settings included MCU and direct sources, both drive polarities and a disabled block");
		if (sb.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
